### design/interval_timer_channel_unit_macros.svh
// Assertion macros shared by the interval timer channel design.
`ifndef INTERVAL_TIMER_CHANNEL_UNIT_MACROS_SVH
`define INTERVAL_TIMER_CHANNEL_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("interval timer channel: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ITC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("interval timer channel: next-cycle check failed");

`endif

### design/itc_pkg.sv
`default_nettype none

package itc_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int COUNT_BITS = 2 * BYTE_BITS;

    // Operation codes of an input word.
    localparam logic [1:0] OP_CONTROL = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Access kinds held in bits 5..4 of a control byte.
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_BOTH  = 2'd3;

    // Channel select value that this channel answers to.
    localparam logic [1:0] CHAN_SELF = 2'd0;

    // Operating modes that count.
    localparam logic [2:0] MODE_INT_TC   = 3'd0;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_RATE_ALT = 3'd6;

    typedef struct packed {
        logic [1:0]           op;
        logic [BYTE_BITS-1:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_BITS-1:0] read_data;
        logic                 out_level;
        logic                 irq_edge;
    } t_out_word;

endpackage

`default_nettype wire

### design/interval_timer_channel_unit.sv
// Interval timer channel: an accepted input word is held in the input register, and its result word
// is then written to the result register, from which it can be taken; an output stall holds the
// word in the input register until the pipeline advances.
// Throughput is one word per cycle; a word is taken every cycle while results are drained.
// Reset is synchronous and active low: the pipeline empties, the counter stops, the access
// kind returns to low-then-high, the mode to zero and the output pin to high.
`default_nettype none

`include "interval_timer_channel_unit_macros.svh"

module interval_timer_channel_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire itc_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output itc_pkg::t_out_word o_out_word
);

    import itc_pkg::*;

    // The pipeline has two stages. The input register captures the word as it is accepted;
    // the result register receives the word's result, and all channel state is updated at
    // the same edge. The whole pipeline advances whenever the result register is empty or
    // its word is being taken, so a stalled output still leaves room for one input word.
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      w_adv;

    // Architectural state of the counter channel.
    logic [COUNT_BITS-1:0] r_count_now, n_count_now;
    logic [COUNT_BITS-1:0] r_reload_value, n_reload_value;
    logic [COUNT_BITS-1:0] r_latched_count, n_latched_count;
    logic                  r_latch_pending, n_latch_pending;
    logic                  r_read_high_next, n_read_high_next;
    logic                  r_write_high_next, n_write_high_next;
    logic [1:0]            r_access_kind, n_access_kind;
    logic [2:0]            r_op_mode, n_op_mode;
    logic                  r_out_pin, n_out_pin;
    logic                  r_counting, n_counting;

    // Working values of the update logic.
    t_out_word             n_out_word;
    logic [BYTE_BITS-1:0]  w_byte;
    logic [1:0]            w_chan;
    logic [1:0]            w_acc;
    logic [2:0]            w_mode;
    logic                  w_load;
    logic [COUNT_BITS-1:0] w_read_src;
    logic [COUNT_BITS-1:0] w_dec;
    logic [BYTE_BITS-1:0]  w_rd;
    logic                  w_rate_mode;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_byte      = r_in_word.data_in;
    assign w_chan      = w_byte[7:6];
    assign w_acc       = w_byte[5:4];
    assign w_mode      = w_byte[3:1];
    assign w_read_src  = r_latch_pending ? r_latched_count : r_count_now;
    assign w_dec       = r_count_now - COUNT_BITS'(1);
    assign w_rate_mode = (r_op_mode == MODE_RATE) || (r_op_mode == MODE_RATE_ALT);

    // Next-state and result logic for the word held in the input register.
    always_comb begin
        n_count_now       = r_count_now;
        n_reload_value    = r_reload_value;
        n_latched_count   = r_latched_count;
        n_latch_pending   = r_latch_pending;
        n_read_high_next  = r_read_high_next;
        n_write_high_next = r_write_high_next;
        n_access_kind     = r_access_kind;
        n_op_mode         = r_op_mode;
        n_out_pin         = r_out_pin;
        n_counting        = r_counting;
        w_load            = 1'b0;
        w_rd              = '0;

        case (r_in_word.op)
            OP_CONTROL: begin
                // Control bytes for other channels, and the read-back code, are ignored.
                // The BCD select bit is ignored as well: counting is always binary.
                if (w_chan == CHAN_SELF) begin
                    if (w_acc == ACC_LATCH) begin
                        // A latch command while a latch is pending has no effect.
                        if (!r_latch_pending) begin
                            n_latched_count = r_count_now;
                            n_latch_pending = 1'b1;
                        end
                    end else begin
                        n_access_kind     = w_acc;
                        n_op_mode         = w_mode;
                        n_latch_pending   = 1'b0;
                        n_read_high_next  = 1'b0;
                        n_write_high_next = 1'b0;
                        n_counting        = 1'b0;
                        n_out_pin         = (w_mode != MODE_INT_TC);
                    end
                end
            end
            OP_WRITE: begin
                case (r_access_kind)
                    ACC_LOW: begin
                        n_reload_value = {{BYTE_BITS{1'b0}}, w_byte};
                        w_load         = 1'b1;
                    end
                    ACC_HIGH: begin
                        n_reload_value = {w_byte, {BYTE_BITS{1'b0}}};
                        w_load         = 1'b1;
                    end
                    ACC_BOTH: begin
                        if (!r_write_high_next) begin
                            // The first byte of a pair stops an interrupt-mode count.
                            n_reload_value    = {r_reload_value[COUNT_BITS-1:BYTE_BITS],
                                                 w_byte};
                            n_write_high_next = 1'b1;
                            if (r_op_mode == MODE_INT_TC) begin
                                n_counting = 1'b0;
                            end
                        end else begin
                            n_reload_value    = {w_byte, r_reload_value[BYTE_BITS-1:0]};
                            n_write_high_next = 1'b0;
                            w_load            = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                // A complete reload value restarts an interrupt-mode count at once; the
                // rate generator only takes it now if it has not yet started, otherwise
                // at its next reload.
                if (w_load) begin
                    if (r_op_mode == MODE_INT_TC) begin
                        n_count_now = n_reload_value;
                        n_out_pin   = 1'b0;
                        n_counting  = 1'b1;
                    end else if (!r_counting) begin
                        n_count_now = n_reload_value;
                        n_counting  = 1'b1;
                    end
                end
            end
            OP_READ: begin
                case (r_access_kind)
                    ACC_LOW: begin
                        w_rd            = w_read_src[BYTE_BITS-1:0];
                        n_latch_pending = 1'b0;
                    end
                    ACC_HIGH: begin
                        w_rd            = w_read_src[COUNT_BITS-1:BYTE_BITS];
                        n_latch_pending = 1'b0;
                    end
                    default: begin
                        // Low then high: the latch is released after the high byte.
                        if (!r_read_high_next) begin
                            w_rd             = w_read_src[BYTE_BITS-1:0];
                            n_read_high_next = 1'b1;
                        end else begin
                            w_rd             = w_read_src[COUNT_BITS-1:BYTE_BITS];
                            n_read_high_next = 1'b0;
                            n_latch_pending  = 1'b0;
                        end
                    end
                endcase
            end
            OP_TICK: begin
                if (r_counting) begin
                    if (r_op_mode == MODE_INT_TC) begin
                        // The count wraps, so a reload of zero runs for 65536 ticks.
                        n_count_now = w_dec;
                        if ((w_dec == '0) && !r_out_pin) begin
                            n_out_pin = 1'b1;
                        end
                    end else if (w_rate_mode) begin
                        // The output is low for the single tick spent at a count of one.
                        if (r_count_now == COUNT_BITS'(1)) begin
                            n_count_now = r_reload_value;
                            n_out_pin   = 1'b1;
                        end else begin
                            n_count_now = w_dec;
                            if (w_dec == COUNT_BITS'(1)) begin
                                n_out_pin = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        n_out_word.read_data = w_rd;
        n_out_word.out_level = n_out_pin;
        n_out_word.irq_edge  = !r_out_pin && n_out_pin;
    end

    // Pipeline control and channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_count_now       <= '0;
            r_reload_value    <= '0;
            r_latched_count   <= '0;
            r_latch_pending   <= 1'b0;
            r_read_high_next  <= 1'b0;
            r_write_high_next <= 1'b0;
            r_access_kind     <= ACC_BOTH;
            r_op_mode         <= MODE_INT_TC;
            r_out_pin         <= 1'b1;
            r_counting        <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv && r_in_valid) begin
                r_count_now       <= n_count_now;
                r_reload_value    <= n_reload_value;
                r_latched_count   <= n_latched_count;
                r_latch_pending   <= n_latch_pending;
                r_read_high_next  <= n_read_high_next;
                r_write_high_next <= n_write_high_next;
                r_access_kind     <= n_access_kind;
                r_op_mode         <= n_op_mode;
                r_out_pin         <= n_out_pin;
                r_counting        <= n_counting;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_adv && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    // An interrupt edge is always reported together with a high output level.
    `ITC_ASSERT_NOW(a_irq_level, i_clk, i_rst_n, r_out_valid && r_out_word.irq_edge, r_out_word.out_level)
    // The output pin only changes when a word passes into the result register.
    `ITC_ASSERT_NOW(a_pin_moves, i_clk, i_rst_n, $fell(r_out_pin) || $rose(r_out_pin), $past(w_adv && r_in_valid))
    // A word in the input register reaches the result register when the pipeline advances.
    `ITC_ASSERT_NEXT(a_advance, i_clk, i_rst_n, w_adv && r_in_valid, r_out_valid)
    // The byte-pair flags are only ever set in low-then-high access.
    `ITC_ASSERT_NOW(a_pair_flags, i_clk, i_rst_n, r_write_high_next || r_read_high_next, r_access_kind == ACC_BOTH)

endmodule

`default_nettype wire
